FILE: hdl/ocme_pkg.sv
package ocme_pkg;

   // Width of an item number, a node count and the excluded count.
   localparam int ITEM_W = 8;

   // Configuration port: one register, word addressed on a 3-bit byte address.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic [ITEM_W-1:0] NODE_COUNT_RESET = 8'd1;

   // Command codes.
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_SOLVE = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // Solve phases: transitive closure, then counting.
   typedef enum logic {
      PH_CLOSE,
      PH_COUNT
   } phase_type;

endpackage

FILE: hdl/order_closure_median_exclusion_unit.sv
// Median exclusion by order closure.
// Input beats arrive on start/busy: a beat is taken when start is high and
// busy is low. cmd = add stores the relation "heavier_item above lighter_item"
// in a row memory of MAX_ITEMS rows; out-of-range items and self relations
// are dropped in the accept cycle. A kept add holds busy high for its row write.
// cmd = solve runs Warshall closure and then counts, for items 1..n, those
// with more than (n-1)/2 items certainly below or above them, with
// n = min(node_count, MAX_ITEMS). One shared row-update unit and one memory
// read port do all the work, one row per cycle, sweeping all MAX_ITEMS rows
// for each pivot. The count shows on rsp_excluded_count with rsp_valid high
// for exactly one cycle, the first cycle with busy low; a new beat may be
// taken in that cycle. The receiver cannot stall, so there is no result
// backpressure. A solve clears the relation matrix when it finishes.
// node_count is written through the APB-style port at byte address 0; the
// user must do so only while the block is idle, which the block does not
// enforce. Synchronous reset clears the sequencer, all row valid bits (so
// the matrix reads as empty at once) and sets node_count to 1.
module order_closure_median_exclusion_unit
   import ocme_pkg::*;
#(
   parameter int MAX_ITEMS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [ITEM_W-1:0]     req_heavier_item,
   input  logic [ITEM_W-1:0]     req_lighter_item,
   // result channel
   output logic                  rsp_valid,
   output logic [ITEM_W-1:0]     rsp_excluded_count,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int N_W   = (CNT_W > ITEM_W) ? CNT_W : ITEM_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ITEMS - 1);

   typedef logic [MAX_ITEMS-1:0] row_type;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       h_idx_ff, h_idx_in;
   logic [IDX_W-1:0]       l_idx_ff, l_idx_in;
   row_type                pivot_ff, pivot_in;
   logic [CNT_W-1:0]       below_ff, below_in;
   logic [CNT_W-1:0]       above_ff, above_in;
   logic [ITEM_W-1:0]      excl_ff, excl_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ITEM_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [ITEM_W-1:0]      node_count_ff;
   row_type                row_vld_ff, row_vld_in;

   // Relation matrix memory and its registered read port.
   row_type                rows_mem [MAX_ITEMS];
   row_type                rd_data_ff;
   logic                   rd_vld_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   row_type                wr_data;

   logic [N_W-1:0]         eff_n;
   logic [N_W-1:0]         thr;
   logic [N_W-1:0]         heavier_n;
   logic [N_W-1:0]         lighter_n;
   logic                   add_ok;
   logic                   accept;
   row_type                cur_row;
   logic                   csr_wr;

   // Effective item count and the median threshold.
   always_comb begin
      eff_n = (N_W'(node_count_ff) > N_W'(MAX_ITEMS)) ? N_W'(MAX_ITEMS)
                                                      : N_W'(node_count_ff);
      thr   = (eff_n == '0) ? '0 : ((eff_n - N_W'(1)) >> 1);
   end

   // Relation check at the accept edge.
   always_comb begin
      heavier_n = N_W'(req_heavier_item);
      lighter_n = N_W'(req_lighter_item);
      add_ok    = (heavier_n != '0) && (lighter_n != '0) &&
                  (heavier_n <= eff_n) && (lighter_n <= eff_n) &&
                  (req_heavier_item != req_lighter_item);
   end

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign cur_row = rd_vld_ff ? rd_data_ff : '0;

   // Sequencer: next state, loop counters and the shared row unit.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      h_idx_in     = h_idx_ff;
      l_idx_in     = l_idx_ff;
      pivot_in     = pivot_ff;
      below_in     = below_ff;
      above_in     = above_ff;
      excl_in      = excl_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      row_vld_in   = row_vld_ff;
      rd_addr      = i_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = cur_row | pivot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_SOLVE) begin
                  phase_in = PH_CLOSE;
                  k_in     = '0;
                  excl_in  = '0;
                  state_in = ST_PIV_RD;
               end else if (add_ok) begin
                  h_idx_in = IDX_W'(heavier_n - N_W'(1));
                  l_idx_in = IDX_W'(lighter_n - N_W'(1));
                  rd_addr  = IDX_W'(heavier_n - N_W'(1));
                  state_in = ST_ADD_WR;
               end
            end
         end

         ST_ADD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = h_idx_ff;
            wr_data  = cur_row | (row_type'(1) << l_idx_ff);
            state_in = ST_IDLE;
         end

         ST_PIV_RD: begin
            rd_addr  = k_ff;
            state_in = ST_PIV_LD;
         end

         ST_PIV_LD: begin
            pivot_in = cur_row;
            below_in = '0;
            above_in = '0;
            rd_addr  = '0;
            i_in     = '0;
            state_in = ST_SWEEP;
         end

         ST_SWEEP: begin
            // Row i arrives from the read port; row k is held in pivot_ff.
            if (phase_ff == PH_CLOSE) begin
               wr_en = cur_row[k_ff];
            end else if (i_ff != k_ff) begin
               if (pivot_ff[i_ff]) begin
                  below_in = below_ff + CNT_W'(1);
               end
               if (cur_row[k_ff]) begin
                  above_in = above_ff + CNT_W'(1);
               end
            end

            if (i_ff != LAST_IDX) begin
               rd_addr = i_ff + IDX_W'(1);
               i_in    = i_ff + IDX_W'(1);
            end else if (phase_ff == PH_CLOSE) begin
               if (k_ff == LAST_IDX) begin
                  phase_in = PH_COUNT;
                  k_in     = '0;
                  state_in = (eff_n == '0) ? ST_FINISH : ST_PIV_RD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_PIV_RD;
               end
            end else begin
               if (((N_W'(below_in) > thr) || (N_W'(above_in) > thr)) &&
                   (excl_ff != '1)) begin
                  excl_in = excl_ff + ITEM_W'(1);
               end
               if (N_W'(k_ff) == (eff_n - N_W'(1))) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_PIV_RD;
               end
            end
         end

         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = excl_ff;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Row valid bits: a write marks the row, a finished solve empties all.
      if (wr_en) begin
         row_vld_in[wr_addr] = 1'b1;
      end
      if (state_ff == ST_FINISH) begin
         row_vld_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CLOSE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         row_vld_ff   <= row_vld_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      i_ff         <= i_in;
      h_idx_ff     <= h_idx_in;
      l_idx_ff     <= l_idx_in;
      pivot_ff     <= pivot_in;
      below_ff     <= below_in;
      above_ff     <= above_in;
      excl_ff      <= excl_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Relation memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= rows_mem[rd_addr];
      rd_vld_ff  <= row_vld_ff[rd_addr];
   end

   // Configuration register.
   assign csr_wr = psel && penable && pwrite && pready &&
                   (paddr[CSR_ADDR_W-1] == REG_NODE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_wr) begin
         node_count_ff <= pwdata[ITEM_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[CSR_ADDR_W-1] == REG_NODE_COUNT) ?
                   CSR_DATA_W'(node_count_ff) : '0;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_excluded_count = rsp_count_ff;

`ifndef SYNTHESIS
   // A result beat only follows the finish step of a solve.
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("result beat without a finished solve");

   // The counting phase never writes the relation memory.
   a_count_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && phase_ff == PH_COUNT) |-> !wr_en)
      else $error("memory write during counting");

   // A finished solve leaves an empty matrix.
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (row_vld_ff == '0))
      else $error("matrix not cleared after solve");

   // Every sweep starts at row zero.
   a_sweep_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIV_LD) |=> (state_ff == ST_SWEEP && i_ff == '0))
      else $error("sweep did not start at row zero");
`endif

endmodule

FILE: sim/order_closure_median_exclusion_unit_test.sv
`timescale 1ns / 100ps

module order_closure_median_exclusion_unit_test
   import ocme_pkg::*;
();

   localparam int MAX_ITEMS = 128;
   localparam int BEAT_GOAL = 950;
   // The last stretch of beats runs with no sender gaps.
   localparam int QUIET_TAIL = 150;
   localparam logic SPARE_REG = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_ADDR = {SPARE_REG, 2'b00};

   // Expected excluded counts, worked out from the relation matrix it keeps.
   class median_exclusion_board;
      bit [MAX_ITEMS-1:0] lighter_of[MAX_ITEMS];
      bit [ITEM_W-1:0] node_count = NODE_COUNT_RESET;
      bit [ITEM_W-1:0] expected_counts[$];
      int unsigned errors = 0;

      function int unsigned items_in_use();
         return (node_count > MAX_ITEMS) ? MAX_ITEMS : node_count;
      endfunction

      function bit takes_relation(bit [ITEM_W-1:0] heavier, bit [ITEM_W-1:0] lighter);
         int unsigned n;
         n = items_in_use();
         return heavier >= 1 && lighter >= 1 && heavier <= n && lighter <= n
                && heavier != lighter;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         if (addr[CSR_ADDR_W-1:2] == REG_NODE_COUNT) begin
            node_count = data[ITEM_W-1:0];
         end
      endfunction

      // Closes the relation matrix, counts the items that cannot be the median,
      // and clears the matrix for the next set.
      function bit [ITEM_W-1:0] close_and_count();
         int unsigned n;
         int unsigned threshold;
         int unsigned below;
         int unsigned excluded;
         int unsigned above[MAX_ITEMS];
         n = items_in_use();
         for (int k = 0; k < MAX_ITEMS; k++) begin
            for (int i = 0; i < MAX_ITEMS; i++) begin
               if (lighter_of[i][k]) begin
                  lighter_of[i] |= lighter_of[k];
               end
            end
         end
         foreach (above[j]) above[j] = 0;
         for (int i = 0; i < MAX_ITEMS; i++) begin
            for (int j = 0; j < MAX_ITEMS; j++) begin
               if (i != j && lighter_of[i][j]) begin
                  above[j]++;
               end
            end
         end
         threshold = (n == 0) ? 0 : (n - 1) / 2;
         excluded = 0;
         // An item sitting in a cycle never counts itself.
         for (int i = 0; i < n; i++) begin
            below = $countones(lighter_of[i]) - lighter_of[i][i];
            if (below > threshold || above[i] > threshold) begin
               excluded++;
            end
         end
         foreach (lighter_of[i]) lighter_of[i] = '0;
         return excluded[ITEM_W-1:0];
      endfunction

      function void note_beat(logic cmd, bit [ITEM_W-1:0] heavier, bit [ITEM_W-1:0] lighter);
         if (cmd == CMD_ADD) begin
            if (takes_relation(heavier, lighter)) begin
               lighter_of[heavier - 1][lighter - 1] = 1'b1;
            end
         end else begin
            expected_counts.insert(expected_counts.size(), close_and_count());
         end
      endfunction

      function void check_count(logic [ITEM_W-1:0] actual);
         bit [ITEM_W-1:0] expected;
         if (expected_counts.size() == 0) begin
            $error("excluded_count: unexpected beat, expected none, actual %0d", actual);
            errors++;
         end else begin
            expected = expected_counts.pop_front();
            if (actual !== expected) begin
               $error("excluded_count mismatch: expected %0d, actual %0d", expected, actual);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = CMD_ADD;
   logic [ITEM_W-1:0] req_heavier_item = '0;
   logic [ITEM_W-1:0] req_lighter_item = '0;
   logic rsp_valid;
   logic [ITEM_W-1:0] rsp_excluded_count;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   median_exclusion_board board = new();
   int unsigned beats_counted = 0;
   bit gaps_on = 1'b1;

   order_closure_median_exclusion_unit #(
      .MAX_ITEMS(MAX_ITEMS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_heavier_item(req_heavier_item),
      .req_lighter_item(req_lighter_item),
      .rsp_valid(rsp_valid),
      .rsp_excluded_count(rsp_excluded_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #10 clock = ~clock;

   // Every result beat is checked against the oldest expected count.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_count(rsp_excluded_count);
      end
   end

   // Sends one beat, with an optional random gap in front of it.
   task automatic send_beat(input logic cmd, input logic [ITEM_W-1:0] heavier,
                            input logic [ITEM_W-1:0] lighter);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_heavier_item <= heavier;
      req_lighter_item <= lighter;
      do @(posedge clock); while (busy);
      beats_counted++;
      board.note_beat(cmd, heavier, lighter);
   endtask

   // Holds the sender off until every count is back and the block is idle.
   task automatic drain_results();
      start <= 1'b0;
      while (board.expected_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.write_reg(addr, data);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // One relation set: mostly consistent with a hidden order, some reversed
   // relations that close cycles, some noise, then a solve.
   task automatic run_random_set(input bit quiet);
      int unsigned pick;
      int unsigned n;
      int unsigned adds;
      int unsigned a;
      int unsigned b;
      int unsigned rank[MAX_ITEMS + 1];
      logic [ITEM_W-1:0] heavier;
      logic [ITEM_W-1:0] lighter;
      pick = $urandom_range(0, 99);
      if (pick < 65) n = $urandom_range(2, 16);
      else if (pick < 80) n = $urandom_range(17, MAX_ITEMS - 1);
      else if (pick < 88) n = MAX_ITEMS;
      else if (pick < 92) n = 0;
      else if (pick < 95) n = 1;
      else n = $urandom_range(MAX_ITEMS + 1, 255);
      csr_write(NODE_COUNT_ADDR, ($urandom() & 32'hFFFF_FF00) | n);
      gaps_on = !quiet && $urandom_range(0, 2) != 0;
      foreach (rank[i]) rank[i] = $urandom();
      adds = $urandom_range(10, 50);
      for (int i = 0; i < adds; i++) begin
         n = board.items_in_use();
         if (n >= 2 && $urandom_range(0, 9) != 0) begin
            a = $urandom_range(1, n);
            do b = $urandom_range(1, n); while (b == a);
            if ((rank[a] > rank[b]) ^ ($urandom_range(0, 19) == 0)) begin
               heavier = a[ITEM_W-1:0];
               lighter = b[ITEM_W-1:0];
            end else begin
               heavier = b[ITEM_W-1:0];
               lighter = a[ITEM_W-1:0];
            end
         end else begin
            heavier = ITEM_W'($urandom());
            lighter = ITEM_W'($urandom());
         end
         // Now and then the item count changes under stored relations.
         if (!quiet && i == adds / 2 && $urandom_range(0, 7) == 0) begin
            csr_write(NODE_COUNT_ADDR, $urandom_range(0, MAX_ITEMS + 20));
         end
         send_beat(CMD_ADD, heavier, lighter);
      end
      send_beat(CMD_SOLVE, ITEM_W'($urandom()), ITEM_W'($urandom()));
   endtask

   // Run timeout.
   initial begin
      repeat (12) #250_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset only one item is in use, so nothing can be excluded.
      send_beat(CMD_SOLVE, 8'hFF, 8'h00);

      // A five-item chain, plus relations outside the items or on themselves.
      csr_write(NODE_COUNT_ADDR, 32'd5);
      send_beat(CMD_ADD, 8'd5, 8'd4);
      send_beat(CMD_ADD, 8'd4, 8'd3);
      send_beat(CMD_ADD, 8'd3, 8'd2);
      send_beat(CMD_ADD, 8'd2, 8'd1);
      send_beat(CMD_ADD, 8'd0, 8'd3);
      send_beat(CMD_ADD, 8'd6, 8'd1);
      send_beat(CMD_ADD, 8'd2, 8'd2);
      send_beat(CMD_SOLVE, 8'h00, 8'hFF);

      // The same chain closed into a cycle: every item lands below itself.
      send_beat(CMD_ADD, 8'd5, 8'd4);
      send_beat(CMD_ADD, 8'd4, 8'd3);
      send_beat(CMD_ADD, 8'd3, 8'd2);
      send_beat(CMD_ADD, 8'd2, 8'd1);
      send_beat(CMD_ADD, 8'd1, 8'd5);
      send_beat(CMD_SOLVE, 8'h55, 8'hAA);

      // Relations stored under ten items, then counted under three.
      csr_write(NODE_COUNT_ADDR, 32'd10);
      send_beat(CMD_ADD, 8'd9, 8'd10);
      send_beat(CMD_ADD, 8'd10, 8'd8);
      send_beat(CMD_ADD, 8'd3, 8'd2);
      send_beat(CMD_ADD, 8'd2, 8'd1);
      csr_write(NODE_COUNT_ADDR, 32'd3);
      send_beat(CMD_SOLVE, 8'd1, 8'd1);

      // No items in use: relations are dropped and the count is zero.
      csr_write(NODE_COUNT_ADDR, 32'd0);
      send_beat(CMD_ADD, 8'd1, 8'd2);
      // A write to the unmapped address must leave node_count alone.
      csr_write(SPARE_REG_ADDR, 32'hFFFF_FFFF);
      send_beat(CMD_SOLVE, 8'hAA, 8'h55);

      // Above the item limit the count saturates to the full matrix.
      csr_write(NODE_COUNT_ADDR, 32'hFFFF_FFC8);
      send_beat(CMD_ADD, 8'd128, 8'd1);
      send_beat(CMD_ADD, 8'd200, 8'd1);
      send_beat(CMD_SOLVE, 8'h80, 8'h7F);

      // Random relation sets; the tail runs without gaps.
      while (beats_counted < BEAT_GOAL) begin
         run_random_set(beats_counted >= BEAT_GOAL - QUIET_TAIL);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
